// ----- rtl/core/mbdc_pkg.sv -----
// Package for the mask block downsample classifier: field widths, codes and the result record.
package mbdc_pkg;

  localparam int PIX_W       = 8;
  localparam int NIB_W       = 4;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int MAP_IDX_W   = 7;
  localparam int TOT_W       = 15;
  localparam int OUT_DATA_W  = 64;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int SETTLE_CYC  = 2;

  localparam logic [NIB_W-1:0] HARD_VAL   = 4'hf;
  localparam logic [NIB_W-1:0] SOFT_LIMIT = 4'd4;
  localparam logic [TOT_W-1:0] TOT_MAX    = 15'h7fff;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_OFFROAD = 2'd1,
    CLS_ROAD    = 2'd2,
    CLS_OTHER   = 2'd3
  } class_t;

  typedef struct packed {
    logic [TOT_W-1:0]     tot_other;
    logic [TOT_W-1:0]     tot_road;
    logic [TOT_W-1:0]     tot_offroad;
    logic                 done;
    logic [MAP_IDX_W-1:0] row;
    logic [MAP_IDX_W-1:0] col;
    class_t               cls;
  } out_item_t;

endpackage

// ----- rtl/core/mbdc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module mbdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mask_block_downsample_classifier_core.sv -----
// Top level of the mask block downsample classifier.
//
// A track mask enters on the in_ stream one pixel per request in raster order; in_tuser
// marks the first pixel of a mask. The cfg_ channel writes the mask width (index 0) and
// height (index 1). When the last pixel of a square block arrives, one result leaves on
// the out_ stream: the block class, its map position and the running class totals, with
// out_tlast set on the final block of the mask.
// The block accumulators sit in one RAM with one entry per map column. Each pixel reads
// its column entry when it is accepted and writes it back in the next cycle; a pixel that
// follows in the next cycle on the same column takes the written value by forwarding.
// Throughput is one pixel per cycle while in_tready is high. A result passes the update stage
// registers and the output queue before it is offered. in_tready is held low after a
// configuration write and after reset, while the block size is recomputed by one multiplier
// per dimension, and whenever the update stage and the four-entry output queue together
// hold three or more results, so a stalled receiver backs up the input.
// cfg_ready is always high. Reset sets both dimensions and the block size to one, clears
// the position, the totals and the output queue; no clearing pass over the RAM is needed.
module mask_block_downsample_classifier_core #(
  parameter int MAP_MAX_W    = 128,
  parameter int MAP_MAX_H    = 128,
  parameter int MASK_MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mbdc_pkg::PIX_W-1:0]     in_tdata,   // [7:0] pixel_value
  input  logic [0:0]                     in_tuser,   // [0] frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] block_class, [8:2] map_col, [15:9] map_row, [30:16] total_offroad,
  // [45:31] total_road, [60:46] total_other, [63:61] zero
  output logic [mbdc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,  // map_done
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbdc_pkg::CFG_W-1:0]     cfg_data
);

  import mbdc_pkg::*;

  localparam int MAP_MIN  = (MAP_MAX_W < MAP_MAX_H) ? MAP_MAX_W : MAP_MAX_H;
  localparam int BS_MAX   = (MASK_MAX_DIM + MAP_MIN - 1) / MAP_MIN;
  localparam int BS_W     = $clog2(BS_MAX + 1);
  localparam int CNT_W    = $clog2(BS_MAX * BS_MAX + 1);
  localparam int DIM_W    = $clog2(MASK_MAX_DIM + 1);
  localparam int PX_W     = $clog2(MASK_MAX_DIM);
  localparam int EXT_W    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int NUM_W    = DIM_W + 1;
  localparam int COL_W    = $clog2(MAP_MAX_W + 1);
  localparam int ROW_W    = $clog2(MAP_MAX_H + 1);
  localparam int ADDR_W   = $clog2(MAP_MAX_W);
  localparam int SH_X     = NUM_W + $clog2(MAP_MAX_W);
  localparam int SH_Y     = NUM_W + $clog2(MAP_MAX_H);
  localparam int RX       = ((1 << SH_X) + MAP_MAX_W - 1) / MAP_MAX_W;
  localparam int RY       = ((1 << SH_Y) + MAP_MAX_H - 1) / MAP_MAX_H;
  localparam int PRODX_W  = SH_X + NUM_W;
  localparam int PRODY_W  = SH_Y + NUM_W;
  localparam int RAM_W    = 3 * CNT_W;
  localparam int SETTLE_W = $clog2(SETTLE_CYC + 1);

  // Configuration and derived block size.
  logic [CFG_W-1:0]    mask_width_r, mask_height_r;
  logic [DIM_W-1:0]    eff_w, eff_h;
  logic [PRODX_W-1:0]  prod_x_r;
  logic [PRODY_W-1:0]  prod_y_r;
  logic [BS_W-1:0]     qx, qy;
  logic [BS_W-1:0]     bs_cfg_r;
  logic [SETTLE_W-1:0] settle_r;

  // Raster position.
  logic [BS_W-1:0]  block_size_r, block_size_nxt;
  logic [PX_W-1:0]  pixel_x_r, pixel_x_nxt;
  logic [DIM_W-1:0] pixel_y_r, pixel_y_nxt;
  logic [BS_W-1:0]  off_x_r, off_x_nxt;
  logic [BS_W-1:0]  off_y_r, off_y_nxt;
  logic [COL_W-1:0] block_col_r, block_col_nxt;
  logic [ROW_W-1:0] block_row_r, block_row_nxt;

  logic             in_acc, fs;
  logic [BS_W-1:0]  bs;
  logic [PX_W-1:0]  px;
  logic [DIM_W-1:0] py;
  logic [BS_W-1:0]  ox, oy;
  logic [COL_W-1:0] bc;
  logic [ROW_W-1:0] br;
  logic             active, last_x, last_y, in_map, end_blk;
  logic [NIB_W-1:0] nib;

  // Update stage.
  logic             s1_v_r, s1_emit_r, s1_first_r, s1_hd_r, s1_sf_r, s1_fs_r, s1_done_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [RAM_W-1:0] ram_rdata, acc_base, acc_new;
  logic             fwd_v_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [RAM_W-1:0] fwd_data_r;
  logic [CNT_W-1:0] cnt_hard, cnt_soft, cnt_pix;
  class_t           cls;
  logic [TOT_W-1:0] tot_off_r, tot_road_r, tot_oth_r;
  logic [TOT_W-1:0] tot_off_nxt, tot_road_nxt, tot_oth_nxt;
  logic [TOT_W-1:0] base_off, base_road, base_oth;

  // Output queue.
  out_item_t        fifo_mem [FIFO_DEPTH];
  out_item_t        push_item, head;
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0] count_r;
  logic             push, pop;

  // Configuration registers and block size derivation.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_width_r  <= CFG_W'(1);
      mask_height_r <= CFG_W'(1);
      settle_r      <= SETTLE_W'(SETTLE_CYC);
      bs_cfg_r      <= BS_W'(1);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_IDX_WIDTH:  mask_width_r  <= cfg_data;
          CFG_IDX_HEIGHT: mask_height_r <= cfg_data;
          default: ;
        endcase
        settle_r <= SETTLE_W'(SETTLE_CYC);
      end else if (settle_r != '0) begin
        settle_r <= settle_r - SETTLE_W'(1);
      end
      bs_cfg_r <= (qy > qx) ? qy : qx;
    end
  end

  always_comb begin
    if (mask_width_r == '0) begin
      eff_w = DIM_W'(1);
    end else if (EXT_W'(mask_width_r) > EXT_W'(MASK_MAX_DIM)) begin
      eff_w = DIM_W'(MASK_MAX_DIM);
    end else begin
      eff_w = DIM_W'(mask_width_r);
    end
    if (mask_height_r == '0) begin
      eff_h = DIM_W'(1);
    end else if (EXT_W'(mask_height_r) > EXT_W'(MASK_MAX_DIM)) begin
      eff_h = DIM_W'(MASK_MAX_DIM);
    end else begin
      eff_h = DIM_W'(mask_height_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_x_r <= PRODX_W'(NUM_W'(eff_w) + NUM_W'(MAP_MAX_W - 1)) * PRODX_W'(RX);
    prod_y_r <= PRODY_W'(NUM_W'(eff_h) + NUM_W'(MAP_MAX_H - 1)) * PRODY_W'(RY);
  end

  assign qx = prod_x_r[SH_X +: BS_W];
  assign qy = prod_y_r[SH_Y +: BS_W];

  // Accept stage: position tracking and RAM read.
  assign in_tready = (settle_r == '0) && ((count_r + (FIFO_AW+1)'(push)) <= (FIFO_AW+1)'(2));
  assign in_acc    = in_tvalid && in_tready;
  assign fs        = in_tuser[0];
  assign nib       = in_tdata[NIB_W-1:0];

  always_comb begin
    bs = fs ? bs_cfg_r : block_size_r;
    px = fs ? '0 : pixel_x_r;
    py = fs ? '0 : pixel_y_r;
    ox = fs ? '0 : off_x_r;
    oy = fs ? '0 : off_y_r;
    bc = fs ? '0 : block_col_r;
    br = fs ? '0 : block_row_r;

    active  = py < eff_h;
    last_x  = ((DIM_W+1)'(px) + (DIM_W+1)'(1)) >= (DIM_W+1)'(eff_w);
    last_y  = ((DIM_W+1)'(py) + (DIM_W+1)'(1)) >= (DIM_W+1)'(eff_h);
    in_map  = (bc < COL_W'(MAP_MAX_W)) && (br < ROW_W'(MAP_MAX_H));
    end_blk = ((((BS_W+1)'(ox) + (BS_W+1)'(1)) >= (BS_W+1)'(bs)) || last_x) &&
              ((((BS_W+1)'(oy) + (BS_W+1)'(1)) >= (BS_W+1)'(bs)) || last_y);

    block_size_nxt = bs;
    pixel_x_nxt    = px;
    pixel_y_nxt    = py;
    off_x_nxt      = ox;
    off_y_nxt      = oy;
    block_col_nxt  = bc;
    block_row_nxt  = br;
    if (active) begin
      if (last_x) begin
        pixel_x_nxt   = '0;
        off_x_nxt     = '0;
        block_col_nxt = '0;
        pixel_y_nxt   = py + DIM_W'(1);
        if (((BS_W+1)'(oy) + (BS_W+1)'(1)) >= (BS_W+1)'(bs)) begin
          off_y_nxt = '0;
          if (br < ROW_W'(MAP_MAX_H)) begin
            block_row_nxt = br + ROW_W'(1);
          end
        end else begin
          off_y_nxt = oy + BS_W'(1);
        end
      end else begin
        pixel_x_nxt = px + PX_W'(1);
        if (((BS_W+1)'(ox) + (BS_W+1)'(1)) >= (BS_W+1)'(bs)) begin
          off_x_nxt = '0;
          if (bc < COL_W'(MAP_MAX_W)) begin
            block_col_nxt = bc + COL_W'(1);
          end
        end else begin
          off_x_nxt = ox + BS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BS_W'(1);
      pixel_x_r    <= '0;
      pixel_y_r    <= '0;
      off_x_r      <= '0;
      off_y_r      <= '0;
      block_col_r  <= '0;
      block_row_r  <= '0;
      s1_v_r       <= 1'b0;
    end else begin
      s1_v_r <= in_acc && active && in_map;
      if (in_acc) begin
        block_size_r <= block_size_nxt;
        pixel_x_r    <= pixel_x_nxt;
        pixel_y_r    <= pixel_y_nxt;
        off_x_r      <= off_x_nxt;
        off_y_r      <= off_y_nxt;
        block_col_r  <= block_col_nxt;
        block_row_r  <= block_row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_emit_r  <= end_blk;
    s1_first_r <= (ox == '0) && (oy == '0);
    s1_hd_r    <= nib == HARD_VAL;
    s1_sf_r    <= nib < SOFT_LIMIT;
    s1_fs_r    <= fs;
    s1_done_r  <= last_x && last_y;
    s1_addr_r  <= ADDR_W'(bc);
    s1_row_r   <= br;
  end

  mbdc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAP_MAX_W)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata (acc_new),
    .raddr (ADDR_W'(bc)),
    .rdata (ram_rdata)
  );

  // Update stage: accumulate, classify and count.
  assign acc_base = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;

  always_comb begin
    if (s1_first_r) begin
      acc_new = {CNT_W'(1), CNT_W'(s1_sf_r), CNT_W'(s1_hd_r)};
    end else begin
      acc_new = {acc_base[2*CNT_W +: CNT_W] + CNT_W'(1),
                 acc_base[CNT_W +: CNT_W] + CNT_W'(s1_sf_r),
                 acc_base[0 +: CNT_W] + CNT_W'(s1_hd_r)};
    end
    cnt_hard = acc_new[0 +: CNT_W];
    cnt_soft = acc_new[CNT_W +: CNT_W];
    cnt_pix  = acc_new[2*CNT_W +: CNT_W];

    if ({cnt_hard, 3'b000} >= (CNT_W+3)'(cnt_pix)) begin
      cls = CLS_ROAD;
    end else if ({cnt_soft, 1'b0} >= (CNT_W+1)'(cnt_pix)) begin
      cls = CLS_OFFROAD;
    end else begin
      cls = CLS_OTHER;
    end

    base_off  = s1_fs_r ? '0 : tot_off_r;
    base_road = s1_fs_r ? '0 : tot_road_r;
    base_oth  = s1_fs_r ? '0 : tot_oth_r;
    tot_off_nxt  = base_off;
    tot_road_nxt = base_road;
    tot_oth_nxt  = base_oth;
    if (s1_emit_r) begin
      case (cls)
        CLS_OFFROAD: if (base_off != TOT_MAX) tot_off_nxt = base_off + TOT_W'(1);
        CLS_ROAD:    if (base_road != TOT_MAX) tot_road_nxt = base_road + TOT_W'(1);
        default:     if (base_oth != TOT_MAX) tot_oth_nxt = base_oth + TOT_W'(1);
      endcase
    end

    push_item.cls         = cls;
    push_item.col         = MAP_IDX_W'(s1_addr_r);
    push_item.row         = MAP_IDX_W'(s1_row_r);
    push_item.done        = s1_done_r;
    push_item.tot_offroad = tot_off_nxt;
    push_item.tot_road    = tot_road_nxt;
    push_item.tot_other   = tot_oth_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r    <= 1'b0;
      tot_off_r  <= '0;
      tot_road_r <= '0;
      tot_oth_r  <= '0;
    end else begin
      fwd_v_r <= s1_v_r;
      if (s1_v_r) begin
        tot_off_r  <= tot_off_nxt;
        tot_road_r <= tot_road_nxt;
        tot_oth_r  <= tot_oth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= acc_new;
  end

  // Output queue.
  assign push       = s1_v_r && s1_emit_r;
  assign out_tvalid = count_r != '0;
  assign pop        = out_tvalid && out_tready;
  assign head       = fifo_mem[rd_ptr_r];
  assign out_tdata  = {3'b000, head.tot_other, head.tot_road, head.tot_offroad,
                       head.row, head.col, head.cls};
  assign out_tlast  = head.done;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (count_r == (FIFO_AW+1)'(FIFO_DEPTH))))
    else $error("Result queue overflow.");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_tready)
    else $error("Pixel accepted while the block size is being recomputed.");

  a_block_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (block_size_r != '0))
    else $error("Latched block size is zero.");

endmodule

// ----- tb/mbdc_block_checker.sv -----
// Checker for the mask block downsample classifier: predicts each block result and compares it.
module mbdc_block_checker
  import mbdc_pkg::*;
#(
  parameter int MAP_MAX_W    = 128,
  parameter int MAP_MAX_H    = 128,
  parameter int MASK_MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    blocks_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROAD_SHARE    = 8;
  localparam int unsigned OFFROAD_SHARE = 2;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      hard_acc [MAP_MAX_W];
  int unsigned      soft_acc [MAP_MAX_W];
  int unsigned      count_acc [MAP_MAX_W];
  int unsigned      blk_size;
  int unsigned      px;
  int unsigned      py;
  int unsigned      ox;
  int unsigned      oy;
  int unsigned      bcol;
  int unsigned      brow;
  int unsigned      tot_offroad;
  int unsigned      tot_road;
  int unsigned      tot_other;
  out_item_t        expected_blocks [$];

  initial begin
    mismatches  = 0;
    blocks_owed = 0;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MASK_MAX_DIM) return MASK_MAX_DIM;
    return v;
  endfunction

  task automatic classify_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned      w;
    int unsigned      h;
    int unsigned      sx;
    int unsigned      sy;
    int unsigned      n;
    logic [NIB_W-1:0] nib;
    logic             last_x;
    logic             last_y;
    class_t           cls;
    out_item_t        res;
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    nib = pix[NIB_W-1:0];
    if (fs) begin
      sx          = (w + MAP_MAX_W - 1) / MAP_MAX_W;
      sy          = (h + MAP_MAX_H - 1) / MAP_MAX_H;
      blk_size    = (sy > sx) ? sy : sx;
      if (blk_size < 1) blk_size = 1;
      px          = 0;
      py          = 0;
      ox          = 0;
      oy          = 0;
      bcol        = 0;
      brow        = 0;
      tot_offroad = 0;
      tot_road    = 0;
      tot_other   = 0;
    end
    if (py >= h) return;
    last_x = (px + 1 >= w);
    last_y = (py + 1 >= h);
    if (bcol < MAP_MAX_W && brow < MAP_MAX_H) begin
      if (ox == 0 && oy == 0) begin
        hard_acc[bcol]  = (nib == HARD_VAL);
        soft_acc[bcol]  = (nib < SOFT_LIMIT);
        count_acc[bcol] = 1;
      end else begin
        hard_acc[bcol]  += (nib == HARD_VAL);
        soft_acc[bcol]  += (nib < SOFT_LIMIT);
        count_acc[bcol] += 1;
      end
      if ((ox + 1 >= blk_size || last_x) && (oy + 1 >= blk_size || last_y)) begin
        n = count_acc[bcol];
        if (hard_acc[bcol] * ROAD_SHARE >= n) cls = CLS_ROAD;
        else if (soft_acc[bcol] * OFFROAD_SHARE >= n) cls = CLS_OFFROAD;
        else cls = CLS_OTHER;
        case (cls)
          CLS_OFFROAD: if (tot_offroad < TOT_MAX) tot_offroad++;
          CLS_ROAD:    if (tot_road < TOT_MAX) tot_road++;
          default:     if (tot_other < TOT_MAX) tot_other++;
        endcase
        res.cls         = cls;
        res.col         = MAP_IDX_W'(bcol);
        res.row         = MAP_IDX_W'(brow);
        res.done        = last_x && last_y;
        res.tot_offroad = TOT_W'(tot_offroad);
        res.tot_road    = TOT_W'(tot_road);
        res.tot_other   = TOT_W'(tot_other);
        expected_blocks.push_back(res);
      end
    end
    if (last_x) begin
      px   = 0;
      ox   = 0;
      bcol = 0;
      py++;
      oy++;
      if (oy >= blk_size) begin
        oy = 0;
        if (brow < MAP_MAX_H) brow++;
      end
    end else begin
      px++;
      ox++;
      if (ox >= blk_size) begin
        ox = 0;
        if (bcol < MAP_MAX_W) bcol++;
      end
    end
  endtask

  task automatic compare_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_block();
    out_item_t want;
    if (expected_blocks.size() == 0) begin
      $display("%0t: unexpected block result, expected none, got tdata %h tlast %b",
               $time, out_tdata, out_tlast);
      mismatches++;
    end else begin
      want = expected_blocks.pop_front();
      compare_field("block_class", want.cls, out_tdata[1:0]);
      compare_field("map_col", want.col, out_tdata[8:2]);
      compare_field("map_row", want.row, out_tdata[15:9]);
      compare_field("total_offroad", want.tot_offroad, out_tdata[30:16]);
      compare_field("total_road", want.tot_road, out_tdata[45:31]);
      compare_field("total_other", want.tot_other, out_tdata[60:46]);
      compare_field("tdata padding", 0, out_tdata[63:61]);
      compare_field("map_done", want.done, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg   = 1;
      height_reg  = 1;
      blk_size    = 1;
      px          = 0;
      py          = 0;
      ox          = 0;
      oy          = 0;
      bcol        = 0;
      brow        = 0;
      tot_offroad = 0;
      tot_road    = 0;
      tot_other   = 0;
      foreach (hard_acc[i]) begin
        hard_acc[i]  = 0;
        soft_acc[i]  = 0;
        count_acc[i] = 0;
      end
      expected_blocks.delete();
    end else begin
      if (out_tvalid && out_tready) check_block();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WIDTH) width_reg = cfg_data;
        else if (cfg_index == CFG_IDX_HEIGHT) height_reg = cfg_data;
      end
      if (in_tvalid && in_tready) classify_pixel(in_tdata, in_tuser[0]);
    end
    blocks_owed = expected_blocks.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, mask stimulus, result receiver and the final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mbdc_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_WAIT   = 6;
  localparam int DRAIN_WAIT    = 16;
  localparam int RANDOM_PIXELS = 350;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  int mismatches;
  int blocks_owed;
  int quiet_cycles = 0;
  bit pace_input   = 1'b1;
  bit pace_output  = 1'b1;
  bit hold_req     = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mask_block_downsample_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mbdc_block_checker block_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .blocks_owed (blocks_owed)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL mask_block_downsample_classifier_core");
      $finish;
    end
  end

  // Result receiver, with one long hold-off on request so that the block backs up.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = pace_output ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = pace_input ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= pix;
    in_tuser[0] <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (blocks_owed != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(input int unsigned w, input int unsigned h);
    settle();
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
  endtask

  function automatic logic [PIX_W-1:0] mask_byte(input int hard_pct, input int soft_pct);
    logic [PIX_W-1:0] b;
    b = PIX_W'($urandom);
    if ($urandom_range(0, 99) < hard_pct) b[NIB_W-1:0] = HARD_VAL;
    else if ($urandom_range(0, 99) < soft_pct) b[NIB_W-1:0] = NIB_W'($urandom_range(0, 3));
    return b;
  endfunction

  task automatic send_frame(input int count, input int hard_pct, input int soft_pct);
    for (int i = 0; i < count; i++) send_pixel(mask_byte(hard_pct, soft_pct), i == 0);
  endtask

  initial begin
    int w;
    int h;
    int len;
    int hard_pct;
    int random_pixels;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Pixels before any frame start use the reset size of one by one; the second is ignored.
    send_pixel(8'hf0, 1'b0);
    send_pixel(8'h5f, 1'b0);
    send_pixel(8'h0f, 1'b1);

    // One-pixel blocks: hard, soft, other and the nibble edges, then a trailing ignored pixel.
    set_dims(3, 2);
    send_pixel(8'hff, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h04, 1'b0);
    send_pixel(8'h83, 1'b0);
    send_pixel(8'h0e, 1'b0);
    send_pixel(8'h7f, 1'b0);
    send_pixel(8'h12, 1'b0);

    // Zero dimensions act as one.
    set_dims(0, 0);
    send_pixel(8'h07, 1'b1);

    // Dimensions changed mid-frame with the size latched at one; columns beyond the map saturate.
    set_dims(4, 3);
    send_pixel(8'h01, 1'b1);
    send_pixel(8'hcf, 1'b0);
    settle();
    write_reg(CFG_IDX_HEIGHT, 1);
    write_reg(CFG_IDX_WIDTH, 140);
    for (int i = 0; i < 140; i++) send_pixel(mask_byte(30, 50), 1'b0);

    // Rows beyond the map saturate after the height grows mid-frame.
    set_dims(1, 1);
    send_pixel(8'h3c, 1'b1);
    settle();
    write_reg(CFG_IDX_HEIGHT, 131);
    for (int i = 0; i < 130; i++) send_pixel(mask_byte(30, 50), 1'b0);

    // Long receiver hold-off while the sender keeps offering one-pixel blocks.
    set_dims(12, 10);
    pace_input = 1'b0;
    hold_req   = 1'b1;
    send_frame(120, 30, 50);
    pace_input = 1'b1;

    // Extreme dimensions: the start of the widest row, and the largest block sizes cut short.
    set_dims(4096, 1);
    send_frame(256, 5, 60);
    set_dims(8191, 2);
    send_frame(40, 12, 50);
    set_dims(1, 4096);
    send_frame(96, 5, 50);
    set_dims(2, 8191);
    send_frame(70, 12, 50);

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(129, 150);
          h = $urandom_range(1, 2);
        end
        1: begin
          w = $urandom_range(1, 2);
          h = $urandom_range(129, 150);
        end
        default: begin
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 10);
        end
      endcase
      case ($urandom_range(0, 3))
        0:       hard_pct = 0;
        1:       hard_pct = 5;
        2:       hard_pct = 12;
        default: hard_pct = 40;
      endcase
      pace_input  = ($urandom_range(0, 3) != 0);
      pace_output = ($urandom_range(0, 3) != 0);
      len = w * h;
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
      set_dims(w, h);
      send_frame(len, hard_pct, $urandom_range(0, 100));
      random_pixels += len;
      if (len == w * h && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_pixel(PIX_W'($urandom), 1'b0);
      end
    end

    in_tvalid <= 1'b0;
    while (blocks_owed != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS mask_block_downsample_classifier_core");
    end else begin
      $display("FAIL mask_block_downsample_classifier_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mbdc_pkg.sv
rtl/core/mbdc_ram.sv
rtl/core/mask_block_downsample_classifier_core.sv
tb/mbdc_block_checker.sv
tb/testbench.sv
